[hdl/assert_macros.svh]
// Assertion macros shared by the heading tracker RTL.
// Expects a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif

`endif

[hdl/dght_pkg.sv]
// Package for the dual gyro heading tracker: widths, fixed-point constants,
// command and register codes, and the request and result structs. No dependencies.
`default_nettype none

package dght_pkg;

	// Field widths.
	localparam int ANGLE_W    = 12;
	localparam int HEAD_W     = 20;
	localparam int SCALE_W    = 16;
	localparam int FUNC_W     = 2;
	localparam int REG_IDX_W  = 2;

	// Angle units and fixed-point formats.
	localparam int FULL_TURN  = 3600;
	localparam int FRAC_BITS  = 8;
	localparam int SCALE_FRAC = 14;
	localparam int FOLD_LIMIT = (FULL_TURN * 25) / 36;
	localparam int TURN_Q     = FULL_TURN << FRAC_BITS;
	localparam int RND_SHIFT  = SCALE_FRAC - FRAC_BITS;

	// Datapath widths of the heading update.
	localparam int DELTA_W    = ANGLE_W + 1;
	localparam int PROD_W     = DELTA_W + SCALE_W;
	localparam int STEP_W     = PROD_W + 1 - RND_SHIFT;
	localparam int SUM_W      = STEP_W + 1;

	// Command codes carried in func.
	localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_ACW_SCALE_A = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CW_SCALE_A  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACW_SCALE_B = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_CW_SCALE_B  = 2'd3;

	// Scale values after reset (Q1.14).
	localparam logic signed [SCALE_W-1:0] ACW_SCALE_RST = -16'sd16944;
	localparam logic signed [SCALE_W-1:0] CW_SCALE_RST  = -16'sd17057;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ANGLE_W-1:0] sample_a;
		logic [ANGLE_W-1:0] sample_b;
		logic [ANGLE_W-1:0] new_heading;
	} req_t;

	typedef struct packed {
		logic [HEAD_W-1:0] heading;
		logic [HEAD_W-1:0] heading_a;
		logic [HEAD_W-1:0] heading_b;
	} rsp_t;

endpackage

`default_nettype wire

[hdl/dual_gyro_heading_tracker.sv]
// Top level of the dual gyro heading tracker: request register, heading state,
// average and result register. Depends on dght_pkg, dght_track, dght_avg, assert_macros.svh.
//
// A request is taken on every cycle in which the result side keeps up. Once accepted,
// it is registered in the request register, the command is then applied to the stored
// headings and readings, and the averaged result is then loaded into the output
// register. The clock period is set by the heading update loop (13 by 16 bit
// multiply, rounding add, accumulate and wrap select), which is combinational so
// that back-to-back samples chain directly.
// Scale registers may be written at any time the block is idle.
`default_nettype none

`include "assert_macros.svh"

module dual_gyro_heading_tracker
	import dght_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  req_t                 in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rsp_t                 out_data
);

	localparam logic [ANGLE_W-1:0] TURN_A    = ANGLE_W'(FULL_TURN);
	localparam logic [HEAD_W-1:0]  HEAD_TURN = HEAD_W'(TURN_Q);

	logic signed [SCALE_W-1:0] acw_scale_a_q;
	logic signed [SCALE_W-1:0] cw_scale_a_q;
	logic signed [SCALE_W-1:0] acw_scale_b_q;
	logic signed [SCALE_W-1:0] cw_scale_b_q;

	logic [HEAD_W-1:0]  acc_a_q;
	logic [HEAD_W-1:0]  acc_b_q;
	logic [ANGLE_W-1:0] prev_a_q;
	logic [ANGLE_W-1:0] prev_b_q;
	logic               primed_q;

	logic               v_s1;
	req_t               req_s1;
	logic               v_s2;
	logic               v_s3;
	rsp_t               rsp_s3;

	logic               ready_s1;
	logic               ready_s2;
	logic               ready_s3;

	logic [HEAD_W-1:0]  next_a;
	logic [HEAD_W-1:0]  next_b;
	logic [ANGLE_W-1:0] nh_mod;
	logic [HEAD_W-1:0]  set_head;
	logic [HEAD_W-1:0]  avg;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acw_scale_a_q <= ACW_SCALE_RST;
			cw_scale_a_q  <= CW_SCALE_RST;
			acw_scale_b_q <= ACW_SCALE_RST;
			cw_scale_b_q  <= CW_SCALE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ACW_SCALE_A: acw_scale_a_q <= $signed(cfg_data);
				REG_CW_SCALE_A:  cw_scale_a_q  <= $signed(cfg_data);
				REG_ACW_SCALE_B: acw_scale_b_q <= $signed(cfg_data);
				REG_CW_SCALE_B:  cw_scale_b_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Each stage moves on when the one after it is empty or moving.
	assign ready_s3 = !v_s3 || !out_stall;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_stall = !ready_s1;

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			req_s1 <= in_data;
		end
	end

	// Per-gyro heading updates from the registered request.
	dght_track u_track_a (
		.acc       (acc_a_q),
		.prev      (prev_a_q),
		.cur       (req_s1.sample_a),
		.acw_scale (acw_scale_a_q),
		.cw_scale  (cw_scale_a_q),
		.next_acc  (next_a)
	);

	dght_track u_track_b (
		.acc       (acc_b_q),
		.prev      (prev_b_q),
		.cur       (req_s1.sample_b),
		.acw_scale (acw_scale_b_q),
		.cw_scale  (cw_scale_b_q),
		.next_acc  (next_b)
	);

	// Heading loaded by the set command, reduced into one turn.
	assign nh_mod   = (req_s1.new_heading >= TURN_A) ? (req_s1.new_heading - TURN_A)
	                                                 : req_s1.new_heading;
	assign set_head = HEAD_W'({nh_mod, {FRAC_BITS{1'b0}}});

	// Command execution. The state stays put while stage two holds its request,
	// so the stored headings double as that stage's payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			acc_a_q  <= '0;
			acc_b_q  <= '0;
			prev_a_q <= '0;
			prev_b_q <= '0;
			primed_q <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				case (req_s1.func)
					FUNC_SAMPLE: begin
						prev_a_q <= req_s1.sample_a;
						prev_b_q <= req_s1.sample_b;
						if (!primed_q) begin
							primed_q <= 1'b1;
							acc_a_q  <= '0;
							acc_b_q  <= '0;
						end else begin
							acc_a_q <= next_a;
							acc_b_q <= next_b;
						end
					end
					FUNC_SET: begin
						acc_a_q <= set_head;
						acc_b_q <= set_head;
					end
					FUNC_CLEAR: begin
						acc_a_q  <= '0;
						acc_b_q  <= '0;
						prev_a_q <= '0;
						prev_b_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// Fused heading from the current pair.
	dght_avg u_avg (
		.head_x (acc_a_q),
		.head_y (acc_b_q),
		.avg    (avg)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			rsp_s3.heading   <= avg;
			rsp_s3.heading_a <= acc_a_q;
			rsp_s3.heading_b <= acc_b_q;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = rsp_s3;

	// Stored headings always stay within one turn.
	`ASSERT_PROP(a_acc_range, (acc_a_q < HEAD_TURN) && (acc_b_q < HEAD_TURN))
	// A delivered average stays within one turn.
	`ASSERT_PROP(a_out_range, v_s3 |-> (rsp_s3.heading < HEAD_TURN))
	// Once primed, the tracker stays primed.
	`ASSERT_NEVER(a_primed_fall, $fell(primed_q))
	// A blocked request register keeps its request.
	`ASSERT_PROP(a_s1_hold, (v_s1 && !ready_s2) |=> (v_s1 && $stable(req_s1)))
	// State does not move while stage two waits on the result register.
	`ASSERT_PROP(a_state_hold, (v_s2 && !ready_s3) |=> ($stable(acc_a_q) && $stable(acc_b_q)))

endmodule

`default_nettype wire

[hdl/dght_track.sv]
// Heading update for one gyro: delta, fold, scale, round, accumulate and wrap.
// Depends on dght_pkg.
`default_nettype none

module dght_track
	import dght_pkg::*;
(
	input  logic [HEAD_W-1:0]         acc,
	input  logic [ANGLE_W-1:0]        prev,
	input  logic [ANGLE_W-1:0]        cur,
	input  logic signed [SCALE_W-1:0] acw_scale,
	input  logic signed [SCALE_W-1:0] cw_scale,
	output logic [HEAD_W-1:0]         next_acc
);

	localparam logic signed [DELTA_W-1:0] FOLD_S     = DELTA_W'(FOLD_LIMIT);
	localparam logic signed [DELTA_W-1:0] TURN_D     = DELTA_W'(FULL_TURN);
	localparam logic signed [PROD_W:0]    RND_HALF_S = (PROD_W+1)'(1 << (RND_SHIFT - 1));
	localparam logic signed [SUM_W-1:0]   TURN_S     = SUM_W'(TURN_Q);
	localparam logic signed [SUM_W-1:0]   TWO_TURN_S = SUM_W'(2 * TURN_Q);

	logic signed [DELTA_W-1:0] diff;
	logic signed [DELTA_W-1:0] delta;
	logic signed [SCALE_W-1:0] scale;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W:0]    prod_rnd;
	logic signed [STEP_W-1:0]  step;
	logic signed [SUM_W-1:0]   raw;
	logic signed [SUM_W-1:0]   wrapped;

	// Negated change since the stored reading, folded across the zero crossing.
	always_comb begin
		diff = DELTA_W'(prev) - DELTA_W'(cur);
		if (diff > FOLD_S) begin
			delta = diff - TURN_D;
		end else if (diff < -FOLD_S) begin
			delta = diff + TURN_D;
		end else begin
			delta = diff;
		end
	end

	// Positive changes use the anticlockwise factor, all others the clockwise one.
	assign scale = (!delta[DELTA_W-1] && (delta != '0)) ? acw_scale : cw_scale;
	assign prod  = delta * scale;

	// Round to the heading format, ties toward plus infinity.
	assign prod_rnd = (PROD_W+1)'(prod) + RND_HALF_S;
	assign step     = STEP_W'(prod_rnd >>> RND_SHIFT);
	assign raw      = SUM_W'(step) + SUM_W'($signed({1'b0, acc}));

	// The sum lies between minus two and plus three turns, so reduce it by picking
	// one offset.
	always_comb begin
		if (raw < -TURN_S) begin
			wrapped = raw + TWO_TURN_S;
		end else if (raw[SUM_W-1]) begin
			wrapped = raw + TURN_S;
		end else if (raw < TURN_S) begin
			wrapped = raw;
		end else if (raw < TWO_TURN_S) begin
			wrapped = raw - TURN_S;
		end else begin
			wrapped = raw - TWO_TURN_S;
		end
	end

	assign next_acc = wrapped[HEAD_W-1:0];

endmodule

`default_nettype wire

[hdl/dght_avg.sv]
// Circular average of two headings that both lie in one turn.
// Depends on dght_pkg.
`default_nettype none

module dght_avg
	import dght_pkg::*;
(
	input  logic [HEAD_W-1:0] head_x,
	input  logic [HEAD_W-1:0] head_y,
	output logic [HEAD_W-1:0] avg
);

	localparam logic [HEAD_W-1:0]        HALF_TURN = HEAD_W'(TURN_Q / 2);
	localparam logic signed [HEAD_W:0]   TURN_W    = (HEAD_W+1)'(TURN_Q);

	logic [HEAD_W-1:0]        lo;
	logic [HEAD_W-1:0]        hi;
	logic signed [HEAD_W:0]   hi_adj;
	logic signed [HEAD_W+1:0] sum;
	logic signed [HEAD_W:0]   half;
	logic signed [HEAD_W:0]   avg_full;

	// Order the pair and pull the larger one a turn down when they straddle zero.
	always_comb begin
		lo = (head_x < head_y) ? head_x : head_y;
		hi = (head_x < head_y) ? head_y : head_x;
		if ((hi - lo) > HALF_TURN) begin
			hi_adj = $signed({1'b0, hi}) - TURN_W;
		end else begin
			hi_adj = $signed({1'b0, hi});
		end
	end

	// Halve the sum rounding down, then bring a negative result back into range.
	always_comb begin
		sum  = (HEAD_W+2)'(hi_adj) + (HEAD_W+2)'($signed({1'b0, lo}));
		half = (HEAD_W+1)'(sum >>> 1);
		if (half[HEAD_W]) begin
			avg_full = half + TURN_W;
		end else begin
			avg_full = half;
		end
	end

	assign avg = avg_full[HEAD_W-1:0];

endmodule

`default_nettype wire
